>>> rtl/core/hu8v_pkg.sv
package hu8v_pkg;

	// Verdict codes carried in the status field
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ODD_LEN   = 3'd1,
		ST_BAD_HEX   = 3'd2,
		ST_BAD_LEAD  = 3'd3,
		ST_BAD_CONT  = 3'd4,
		ST_TRUNC     = 3'd5,
		ST_BAD_CODE  = 3'd6
	} status_t;

	// One character request
	typedef struct packed {
		logic [7:0] hex_char;
		logic       has_char;
		logic       last;
	} char_req_t;

	// One result request
	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_ready;
		logic       string_end;
		status_t    status;
	} res_req_t;

	localparam int CP_W = 21;

	localparam logic [7:0]      LEAD2_LO = 8'hc2;
	localparam logic [7:0]      LEAD2_HI = 8'hdf;
	localparam logic [7:0]      LEAD3_LO = 8'he0;
	localparam logic [7:0]      LEAD3_HI = 8'hef;
	localparam logic [7:0]      LEAD4_LO = 8'hf0;
	localparam logic [7:0]      LEAD4_HI = 8'hf4;
	localparam logic [7:0]      CONT_MASK = 8'hc0;
	localparam logic [7:0]      CONT_TAG  = 8'h80;
	localparam logic [CP_W-1:0] MIN_2B    = 21'h00080;
	localparam logic [CP_W-1:0] MIN_3B    = 21'h00800;
	localparam logic [CP_W-1:0] MIN_4B    = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h0d800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h0dfff;

	// Bit 4 set means not a hex digit
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] v;
		begin
			if (c >= 8'h30 && c <= 8'h39) begin
				v = {1'b0, c[3:0]};
			end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
				v = {1'b0, c[3:0] + 4'd9};
			end else begin
				v = 5'h10;
			end
			return v;
		end
	endfunction

endpackage

>>> rtl/core/hex_utf8_string_validator_top.sv
// Hex string decoder with strict UTF-8 checking. Characters arrive one per
// request on the char channel (has_char low with last low is an idle request,
// has_char low with last high closes the string without a character). Every
// request yields exactly one result request: a completed digit pair puts out
// its byte with byte_ready set, and the last request of a string carries the
// verdict in status with string_end set. Priority of the verdict: odd length,
// then a non-hex character, then the first UTF-8 fault (bad lead, bad
// continuation, truncated sequence, overlong/surrogate/out-of-range code
// point). After a verdict the decoder starts afresh. One request is taken
// every clock unless char_stall is high; a request passes through an input
// register and then a result register. The single decode stage sets the
// rate: all decoder state updates in the cycle a request leaves the input
// register. char_stall follows res_stall while a result is held.
module hex_utf8_string_validator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  hu8v_pkg::char_req_t  char_req,
	output logic                 res_valid,
	input  logic                 res_stall,
	output hu8v_pkg::res_req_t   res_req
);

	localparam int CPW = hu8v_pkg::CP_W;

	// whole pipe moves unless a held result is stalled
	logic advance;
	assign advance    = !(res_valid && res_stall);
	assign char_stall = !advance;

	// input register
	logic                s1_valid_s1;
	hu8v_pkg::char_req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (advance) begin
			s1_valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && char_valid) begin
			req_s1 <= char_req;
		end
	end

	// decoder state
	logic                half_pending_q;
	logic [3:0]          high_nibble_q;
	logic [1:0]          cont_left_q;
	logic [1:0]          cont_total_q;
	logic [CPW-1:0]      code_point_q;
	logic                bad_digit_q;
	hu8v_pkg::status_t   utf_err_q;

	logic                half_pending_d;
	logic [3:0]          high_nibble_d;
	logic [1:0]          cont_left_d;
	logic [1:0]          cont_total_d;
	logic [CPW-1:0]      code_point_d;
	logic                bad_digit_d;
	hu8v_pkg::status_t   utf_err_d;
	hu8v_pkg::res_req_t  res_d;

	logic [4:0]          dval;
	logic [3:0]          nib;
	logic [7:0]          b;
	logic [CPW-1:0]      cp_new;
	logic [CPW-1:0]      cp_min;

	always_comb begin
		dval = hu8v_pkg::digit_value(req_s1.hex_char);
		nib  = dval[4] ? 4'd0 : dval[3:0];
		b    = {high_nibble_q, nib};
		cp_new = {code_point_q[CPW-7:0], b[5:0]};
		case (cont_total_q)
			2'd1:    cp_min = hu8v_pkg::MIN_2B;
			2'd2:    cp_min = hu8v_pkg::MIN_3B;
			default: cp_min = hu8v_pkg::MIN_4B;
		endcase

		half_pending_d = half_pending_q;
		high_nibble_d  = high_nibble_q;
		cont_left_d    = cont_left_q;
		cont_total_d   = cont_total_q;
		code_point_d   = code_point_q;
		bad_digit_d    = bad_digit_q;
		utf_err_d      = utf_err_q;
		res_d          = '0;

		if (req_s1.has_char) begin
			if (dval[4]) begin
				bad_digit_d = 1'b1;
			end
			if (!half_pending_q) begin
				high_nibble_d  = nib;
				half_pending_d = 1'b1;
			end else begin
				res_d.byte_out   = b;
				res_d.byte_ready = 1'b1;
				half_pending_d   = 1'b0;
				high_nibble_d    = 4'd0;
				// UTF-8 check of the completed byte
				if (utf_err_q != hu8v_pkg::ST_OK) begin
					// a bad continuation still counts down its sequence
					if (utf_err_q == hu8v_pkg::ST_BAD_CONT && cont_left_q != 2'd0) begin
						cont_left_d = cont_left_q - 2'd1;
					end
				end else if (cont_left_q == 2'd0) begin
					if (!b[7]) begin
						// plain ASCII
					end else if (b >= hu8v_pkg::LEAD2_LO && b <= hu8v_pkg::LEAD2_HI) begin
						cont_left_d  = 2'd1;
						cont_total_d = 2'd1;
						code_point_d = {{(CPW-5){1'b0}}, b[4:0]};
					end else if (b >= hu8v_pkg::LEAD3_LO && b <= hu8v_pkg::LEAD3_HI) begin
						cont_left_d  = 2'd2;
						cont_total_d = 2'd2;
						code_point_d = {{(CPW-4){1'b0}}, b[3:0]};
					end else if (b >= hu8v_pkg::LEAD4_LO && b <= hu8v_pkg::LEAD4_HI) begin
						cont_left_d  = 2'd3;
						cont_total_d = 2'd3;
						code_point_d = {{(CPW-3){1'b0}}, b[2:0]};
					end else begin
						utf_err_d = hu8v_pkg::ST_BAD_LEAD;
					end
				end else begin
					cont_left_d = cont_left_q - 2'd1;
					if ((b & hu8v_pkg::CONT_MASK) != hu8v_pkg::CONT_TAG) begin
						utf_err_d = hu8v_pkg::ST_BAD_CONT;
					end else begin
						code_point_d = cp_new;
						if (cont_left_q == 2'd1) begin
							if (cp_new < cp_min || cp_new > hu8v_pkg::CP_MAX ||
							    (cp_new >= hu8v_pkg::SURR_LO && cp_new <= hu8v_pkg::SURR_HI)) begin
								utf_err_d = hu8v_pkg::ST_BAD_CODE;
							end
						end
					end
				end
			end
		end

		if (req_s1.last) begin
			res_d.string_end = 1'b1;
			if (half_pending_d) begin
				res_d.status = hu8v_pkg::ST_ODD_LEN;
			end else if (bad_digit_d) begin
				res_d.status = hu8v_pkg::ST_BAD_HEX;
			end else if (utf_err_d == hu8v_pkg::ST_BAD_CONT && cont_left_d != 2'd0) begin
				res_d.status = hu8v_pkg::ST_TRUNC;
			end else if (utf_err_d != hu8v_pkg::ST_OK) begin
				res_d.status = utf_err_d;
			end else if (cont_left_d != 2'd0) begin
				res_d.status = hu8v_pkg::ST_TRUNC;
			end else begin
				res_d.status = hu8v_pkg::ST_OK;
			end
			half_pending_d = 1'b0;
			high_nibble_d  = 4'd0;
			cont_left_d    = 2'd0;
			cont_total_d   = 2'd0;
			code_point_d   = '0;
			bad_digit_d    = 1'b0;
			utf_err_d      = hu8v_pkg::ST_OK;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_pending_q <= 1'b0;
			high_nibble_q  <= 4'd0;
			cont_left_q    <= 2'd0;
			cont_total_q   <= 2'd0;
			code_point_q   <= '0;
			bad_digit_q    <= 1'b0;
			utf_err_q      <= hu8v_pkg::ST_OK;
			res_valid      <= 1'b0;
		end else if (advance) begin
			res_valid <= s1_valid_s1;
			if (s1_valid_s1) begin
				half_pending_q <= half_pending_d;
				high_nibble_q  <= high_nibble_d;
				cont_left_q    <= cont_left_d;
				cont_total_q   <= cont_total_d;
				code_point_q   <= code_point_d;
				bad_digit_q    <= bad_digit_d;
				utf_err_q      <= utf_err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_s1) begin
			res_req <= res_d;
		end
	end

endmodule

>>> dv/hex_utf8_string_validator_top_tb.sv
module hex_utf8_string_validator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and the two channels. Every input has a known value from time zero.
	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	hu8v_pkg::char_req_t char_req   = '0;
	logic                res_valid;
	logic                res_stall  = 1'b0;
	hu8v_pkg::res_req_t  res_req;

	hex_utf8_string_validator_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_req   (char_req),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_req    (res_req)
	);

	always #1 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Decoder shadow state, mirrors the block between verdicts
	// ------------------------------------------------------------------
	bit                nib_held;
	logic [3:0]        held_nib;
	logic [1:0]        conts_left;
	logic [1:0]        conts_total;
	logic [20:0]       cp_acc;
	bit                non_hex_seen;
	hu8v_pkg::status_t utf_fault;      // first UTF-8 fault, ST_OK while none

	hu8v_pkg::res_req_t pending_results[$];  // one expected result per accepted request
	int                 n_fail = 0;

	// Shared pacing controls
	bit quiet      = 1'b0;  // both sides run flat out
	bit long_hold  = 1'b0;  // asks the receiver for one long hold-off
	bit rx_holding = 1'b0;  // receiver is in that hold-off; sender keeps offering

	// Nibble value of an ASCII hex digit; bit 4 flags a non-hex character
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
		return 5'h10;
	endfunction

	function automatic void clear_decoder();
		nib_held     = 1'b0;
		held_nib     = '0;
		conts_left   = '0;
		conts_total  = '0;
		cp_acc       = '0;
		non_hex_seen = 1'b0;
		utf_fault    = hu8v_pkg::ST_OK;
	endfunction

	// Strict UTF-8 tracking of one decoded byte
	function automatic void utf8_track(input logic [7:0] b);
		logic [20:0] floor_cp;
		if (utf_fault != hu8v_pkg::ST_OK) begin
			// only a bad continuation keeps counting down its sequence,
			// so a string cut short still reads as truncated
			if (utf_fault == hu8v_pkg::ST_BAD_CONT && conts_left != 0) conts_left--;
			return;
		end
		if (conts_left == 0) begin
			if (b < 8'h80) return;
			if (b >= hu8v_pkg::LEAD2_LO && b <= hu8v_pkg::LEAD2_HI) begin
				conts_left = 2'd1; conts_total = 2'd1; cp_acc = {16'd0, b[4:0]};
			end else if (b >= hu8v_pkg::LEAD3_LO && b <= hu8v_pkg::LEAD3_HI) begin
				conts_left = 2'd2; conts_total = 2'd2; cp_acc = {17'd0, b[3:0]};
			end else if (b >= hu8v_pkg::LEAD4_LO && b <= hu8v_pkg::LEAD4_HI) begin
				conts_left = 2'd3; conts_total = 2'd3; cp_acc = {18'd0, b[2:0]};
			end else begin
				utf_fault = hu8v_pkg::ST_BAD_LEAD;
			end
			return;
		end
		conts_left--;
		if ((b & hu8v_pkg::CONT_MASK) != hu8v_pkg::CONT_TAG) begin
			utf_fault = hu8v_pkg::ST_BAD_CONT;
			return;
		end
		cp_acc = {cp_acc[14:0], b[5:0]};
		if (conts_left == 0) begin
			floor_cp = (conts_total == 2'd1) ? hu8v_pkg::MIN_2B :
			           (conts_total == 2'd2) ? hu8v_pkg::MIN_3B : hu8v_pkg::MIN_4B;
			if (cp_acc < floor_cp || cp_acc > hu8v_pkg::CP_MAX ||
			    (cp_acc >= hu8v_pkg::SURR_LO && cp_acc <= hu8v_pkg::SURR_HI))
				utf_fault = hu8v_pkg::ST_BAD_CODE;
		end
	endfunction

	// Result request that one accepted character request gives
	function automatic hu8v_pkg::res_req_t decoded_result(input hu8v_pkg::char_req_t r);
		hu8v_pkg::res_req_t o;
		logic [4:0]         nv;
		logic [7:0]         b;
		o = '0;
		if (r.has_char) begin
			nv = nibble_of(r.hex_char);
			if (nv[4]) begin
				non_hex_seen = 1'b1;
				nv = '0;
			end
			if (!nib_held) begin
				held_nib = nv[3:0];
				nib_held = 1'b1;
			end else begin
				b = {held_nib, nv[3:0]};
				o.byte_out   = b;
				o.byte_ready = 1'b1;
				nib_held     = 1'b0;
				held_nib     = '0;
				utf8_track(b);
			end
		end
		if (r.last) begin
			o.string_end = 1'b1;
			if (nib_held)
				o.status = hu8v_pkg::ST_ODD_LEN;
			else if (non_hex_seen)
				o.status = hu8v_pkg::ST_BAD_HEX;
			else if (utf_fault == hu8v_pkg::ST_BAD_CONT && conts_left != 0)
				o.status = hu8v_pkg::ST_TRUNC;
			else if (utf_fault != hu8v_pkg::ST_OK)
				o.status = utf_fault;
			else if (conts_left != 0)
				o.status = hu8v_pkg::ST_TRUNC;
			else
				o.status = hu8v_pkg::ST_OK;
			clear_decoder();
		end
		return o;
	endfunction

	function automatic hu8v_pkg::char_req_t pack_char(input logic [7:0] ch, input bit has,
			input bit fin);
		hu8v_pkg::char_req_t r;
		r.hex_char = ch;
		r.has_char = has;
		r.last     = fin;
		return r;
	endfunction

	// ASCII digit for a nibble, letters in either case
	function automatic logic [7:0] hex_char_of(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// Wait drawn per request: none while quiet, otherwise none half the time
	function automatic int draw_wait();
		if (quiet) return 0;
		return $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 16));
	endfunction

	// Offer one character request and hold it until taken. Called and
	// returns at a falling edge; valid stays high into the next call, which
	// lowers it only if it draws a gap.
	task automatic send_req(input hu8v_pkg::char_req_t r, input bit typed,
			input hu8v_pkg::res_req_t want);
		int                 gap;
		hu8v_pkg::res_req_t pred;
		gap = rx_holding ? 0 : draw_wait();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_req   <= r;
		char_valid <= 1'b1;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		pred = decoded_result(r);
		pending_results.insert(pending_results.size(), typed ? want : pred);
		@(negedge clk);
	endtask

	// Directed row: expectation typed in only where it is obvious
	typedef struct {
		hu8v_pkg::char_req_t req;
		bit                  typed;
		hu8v_pkg::res_req_t  want;
	} dir_row_t;

	function automatic dir_row_t row(input logic [7:0] ch, input bit has, input bit fin,
			input bit typed = 1'b0, input logic [7:0] b = 8'h00, input bit rdy = 1'b0,
			input hu8v_pkg::status_t st = hu8v_pkg::ST_OK);
		dir_row_t d;
		d.req             = pack_char(ch, has, fin);
		d.typed           = typed;
		d.want.byte_out   = b;
		d.want.byte_ready = rdy;
		d.want.string_end = fin;
		d.want.status     = st;
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall per result, plus the long hold-offs
	// ------------------------------------------------------------------
	initial begin : rx_side
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold  = 1'b0;
				rx_holding = 1'b1;
				n = 300;
			end else begin
				n = draw_wait();
			end
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			rx_holding = 1'b0;
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Every taken result request against the oldest expectation
	always @(posedge clk) begin : res_check
		hu8v_pkg::res_req_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result request: byte_out %0h status %0d",
					res_req.byte_out, res_req.status);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				if (res_req.byte_out !== want.byte_out) begin
					$error("byte_out: expected %0h, got %0h", want.byte_out, res_req.byte_out);
					n_fail++;
				end
				if (res_req.byte_ready !== want.byte_ready) begin
					$error("byte_ready: expected %0d, got %0d", want.byte_ready, res_req.byte_ready);
					n_fail++;
				end
				if (res_req.string_end !== want.string_end) begin
					$error("string_end: expected %0d, got %0d", want.string_end, res_req.string_end);
					n_fail++;
				end
				if (res_req.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_req.status);
					n_fail++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stim
		dir_row_t    dir_tbl[$];
		logic [7:0]  seq_bytes[$];
		logic [7:0]  txt[$];
		logic [20:0] cp;
		logic [7:0]  lead;
		int          n_conts;
		int          pick;
		int          mangle;
		int          n_items;
		int          next_hold;
		bit          tail;

		clear_decoder();

		// Directed table
		dir_tbl = {dir_tbl, row(8'h00, 1'b0, 1'b1, 1'b1)};      // empty string
		dir_tbl = {dir_tbl, row(8'hff, 1'b0, 1'b0, 1'b1)};      // idle request
		dir_tbl = {dir_tbl, row("4", 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, hu8v_pkg::ST_ODD_LEN)};
		// non-hex character in a pair still gives a byte, nibble taken as 0
		dir_tbl = {dir_tbl, row("0", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row(8'hff, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, hu8v_pkg::ST_BAD_HEX)};
		dir_tbl = {dir_tbl, row("C", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("0", 1'b1, 1'b1, 1'b1, 8'hc0, 1'b1, hu8v_pkg::ST_BAD_LEAD)};
		// bad continuation inside a sequence the string cuts short: truncated
		dir_tbl = {dir_tbl, row("e", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("2", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("2", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("8", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row(8'h00, 1'b0, 1'b1)};            // end, no char
		// complete sequence with a bad continuation
		dir_tbl = {dir_tbl, row("c", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("3", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("4", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("1", 1'b1, 1'b1, 1'b1, 8'h41, 1'b1, hu8v_pkg::ST_BAD_CONT)};
		// overlong three-byte form
		dir_tbl = {dir_tbl, row("E", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("0", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("8", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("0", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("8", 1'b1, 1'b0)};
		dir_tbl = {dir_tbl, row("0", 1'b1, 1'b1, 1'b1, 8'h80, 1'b1, hu8v_pkg::ST_BAD_CODE)};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tbl[i])
			send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);

		// Random strings: mostly well-formed UTF-8 with random content,
		// some boundary code points, some noise bytes and mangled text
		n_items   = 0;
		next_hold = 400;
		while (n_items < 1600) begin
			quiet = ($urandom_range(0, 7) == 0);
			if (n_items >= next_hold) begin
				long_hold = 1'b1;
				next_hold += 700;
			end
			seq_bytes.delete();
			txt.delete();
			repeat ($urandom_range(0, 5)) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					case ($urandom_range(1, 4))
						1: seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(0, 127)));
						2: begin
							cp = 21'($urandom_range('h80, 'h7ff));
							seq_bytes.insert(seq_bytes.size(), {3'b110, cp[10:6]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
						end
						3: begin
							cp = 21'($urandom_range('h800, 'hffff));
							if (cp >= hu8v_pkg::SURR_LO && cp <= hu8v_pkg::SURR_HI)
								cp ^= 21'h04000;
							seq_bytes.insert(seq_bytes.size(), {4'b1110, cp[15:12]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
						end
						default: begin
							cp = 21'($urandom_range('h10000, 'h10ffff));
							seq_bytes.insert(seq_bytes.size(), {5'b11110, cp[20:18]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[17:12]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
							seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
						end
					endcase
				end else if (pick < 8) begin
					// leads whose range edges give overlong, surrogate or too-large points
					case ($urandom_range(0, 3))
						0:       begin lead = 8'he0; n_conts = 2; end
						1:       begin lead = 8'hed; n_conts = 2; end
						2:       begin lead = 8'hf0; n_conts = 3; end
						default: begin lead = 8'hf4; n_conts = 3; end
					endcase
					seq_bytes.insert(seq_bytes.size(), lead);
					repeat (n_conts)
						seq_bytes.insert(seq_bytes.size(), 8'h80 | 8'($urandom_range(0, 63)));
				end else begin
					seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(0, 255)));
				end
			end

			mangle = $urandom_range(0, 15);
			if (mangle == 0 && seq_bytes.size() > 0) seq_bytes.delete(seq_bytes.size() - 1);
			foreach (seq_bytes[i]) begin
				txt.insert(txt.size(), hex_char_of(seq_bytes[i][7:4]));
				txt.insert(txt.size(), hex_char_of(seq_bytes[i][3:0]));
			end
			if (mangle == 1 && txt.size() > 0)
				txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
			if (mangle == 2 && txt.size() > 0) txt.delete(txt.size() - 1);
			if (mangle == 3) txt.insert(txt.size(), hex_char_of(4'($urandom_range(0, 15))));

			// close on the final character, or by a separate request without one
			tail = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
			foreach (txt[i]) begin
				if ($urandom_range(0, 19) == 0)
					send_req(pack_char(8'($urandom_range(0, 255)), 1'b0, 1'b0), 1'b0, '0);
				send_req(pack_char(txt[i], 1'b1, !tail && i == txt.size() - 1), 1'b0, '0);
				n_items++;
			end
			if (tail) begin
				send_req(pack_char(8'($urandom_range(0, 255)), 1'b0, 1'b1), 1'b0, '0);
				n_items++;
			end
		end

		char_valid <= 1'b0;
		quiet = 1'b0;

		// Drain, then keep watching for anything stray
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (n_fail == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
